// ----- sv/t2ms_pkg.sv -----
package t2ms_pkg;

    localparam int MS_W  = 55;
    localparam int TOD_W = 27;

    // divide-by-1000 step: estimate = (n * RECIP_MS) >> 32, low by at most one
    localparam logic [9:0]  US_PER_MS = 10'd1000;
    localparam logic [22:0] RECIP_MS  = 23'd4294967;

    // 86400000 = 84375 * 2^10, so ms mod day = ((ms >> 10) mod 84375) * 2^10 + ms[9:0]
    localparam logic [26:0] MS_PER_DAY = 27'd86400000;
    localparam logic [16:0] DAY_DIV    = 17'd84375;
    localparam logic [15:0] RECIP_DAY  = 16'd50903;
    localparam int          DAY_SHIFT  = 10;

    typedef struct packed {
        logic [31:0] upper_first;
        logic [31:0] lower_word;
        logic [31:0] upper_second;
    } t_in_item;

    typedef struct packed {
        logic             status;
        logic [MS_W-1:0]  ms_since_epoch;
        logic [TOD_W-1:0] ms_since_midnight;
    } t_out_item;

    // divider -> day modulo
    typedef struct packed {
        logic            torn;
        logic [MS_W-1:0] ms;
    } t_ms_item;

    // day modulo -> time-of-day stage
    typedef struct packed {
        logic             torn;
        logic [MS_W-1:0]  ms;
        logic [TOD_W-1:0] ms_mod_day;
    } t_day_item;

endpackage

// ----- sv/timestamp_to_ms_time_of_day_core.sv -----
// Converts one three-part read of a 64-bit microsecond counter (upper word, lower
// word, upper word again) into milliseconds since the epoch and milliseconds since
// midnight. If the second upper word is higher the lower word is taken as zero; if
// it is lower the read is torn: status is 1, both time fields are 0 and the stored
// midnight is untouched. The count is divided by 1000 exactly (floor), and the time
// of day is measured from a stored midnight that moves to the last whole-day mark
// at or below the current time whenever the gap is a day or more, or negative.
// Midnight resets to 0. Throughput is one item per clock while the output is not
// stalled. The path is 11 register stages: three divide-by-1000 chunks (32/16/16
// bits) and two modulo-84375 steps, each a reciprocal-multiply stage plus a correction
// stage, then one time-of-day stage that owns the midnight register. The first stage
// loads on the input accept edge. Backpressure stalls only stages that are full, so
// bubbles are squeezed out while a result waits.
module timestamp_to_ms_time_of_day_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t2ms_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t2ms_pkg::t_out_item  o_out_item
);

    // divider -> modulo
    logic                div_vld, div_rdy;
    t2ms_pkg::t_ms_item  div_item;
    // modulo -> time of day
    logic                mod_vld, mod_rdy;
    t2ms_pkg::t_day_item mod_item;

    // count / 1000
    t2ms_ms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (div_vld),
        .i_ready (div_rdy),
        .o_item  (div_item)
    );

    // ms mod one day, for resyncing midnight
    t2ms_day_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_vld),
        .o_ready (div_rdy),
        .i_item  (div_item),
        .o_valid (mod_vld),
        .i_ready (mod_rdy),
        .o_item  (mod_item)
    );

    // gap check, midnight update, output register
    t2ms_tod u_tod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mod_vld),
        .o_ready (mod_rdy),
        .i_item  (mod_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ----- sv/t2ms_ms_div.sv -----
// Counter / 1000 as long division in 32/16/16-bit chunks.
// Each chunk: multiply stage (reciprocal estimate), then correction stage.
module t2ms_ms_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t2ms_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output t2ms_pkg::t_ms_item  o_item
);

    typedef struct packed {
        logic [22:0] q;
        logic [9:0]  r;
    } t_qr;

    function automatic logic [22:0] f_est (input logic [31:0] n);
        logic [54:0] p;
        p = 55'(n) * 55'(t2ms_pkg::RECIP_MS);
        return p[54:32];
    endfunction

    function automatic t_qr f_fix (input logic [31:0] n, input logic [22:0] est);
        logic [31:0] back;
        logic [31:0] diff;
        t_qr         res;
        back = 32'(est) * 32'(t2ms_pkg::US_PER_MS);
        diff = n - back;   // below 2000
        if (diff[10:0] >= 11'(t2ms_pkg::US_PER_MS)) begin
            res.q = est + 23'd1;
            res.r = 10'(diff[10:0] - 11'(t2ms_pkg::US_PER_MS));
        end else begin
            res.q = est;
            res.r = diff[9:0];
        end
        return res;
    endfunction

    // stage A: upper word estimate
    logic        r_a_vld, r_a_torn;
    logic [31:0] r_a_lo, r_a_n;
    logic [22:0] r_a_est;
    // stage B: upper word quotient and remainder
    logic        r_b_vld, r_b_torn;
    logic [31:0] r_b_lo;
    t_qr         r_b_qr;
    // stage C: middle chunk estimate
    logic        r_c_vld, r_c_torn;
    logic [15:0] r_c_lo;
    logic [22:0] r_c_qh, r_c_est;
    logic [31:0] r_c_n;
    // stage D: middle chunk fixed
    logic        r_d_vld, r_d_torn;
    logic [15:0] r_d_lo;
    logic [22:0] r_d_qh;
    t_qr         r_d_qr;
    // stage E: low chunk estimate
    logic        r_e_vld, r_e_torn;
    logic [22:0] r_e_qh, r_e_est;
    logic [15:0] r_e_qm;
    logic [31:0] r_e_n;
    // stage F: result
    logic                       r_f_vld, r_f_torn;
    logic [t2ms_pkg::MS_W-1:0]  r_f_ms;

    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    t_qr  fix_b, fix_d, fix_f;
    logic [31:0] n_c_n, n_e_n;

    assign rdy_f = !r_f_vld || i_ready;
    assign rdy_e = !r_e_vld || rdy_f;
    assign rdy_d = !r_d_vld || rdy_e;
    assign rdy_c = !r_c_vld || rdy_d;
    assign rdy_b = !r_b_vld || rdy_c;
    assign rdy_a = !r_a_vld || rdy_b;
    assign o_ready = rdy_a;

    always_comb begin
        fix_b = f_fix(r_a_n, r_a_est);
        n_c_n = {6'd0, r_b_qr.r, r_b_lo[31:16]};
        fix_d = f_fix(r_c_n, r_c_est);
        n_e_n = {6'd0, r_d_qr.r, r_d_lo};
        fix_f = f_fix(r_e_n, r_e_est);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_valid;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
            if (rdy_e) r_e_vld <= r_d_vld;
            if (rdy_f) r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_torn <= i_item.upper_second < i_item.upper_first;
            // upper word rolled: lower word counts as zero
            r_a_lo   <= (i_item.upper_second > i_item.upper_first) ? 32'd0 : i_item.lower_word;
            r_a_n    <= i_item.upper_second;
            r_a_est  <= f_est(i_item.upper_second);
        end
        if (rdy_b && r_a_vld) begin
            r_b_torn <= r_a_torn;
            r_b_lo   <= r_a_lo;
            r_b_qr   <= fix_b;
        end
        if (rdy_c && r_b_vld) begin
            r_c_torn <= r_b_torn;
            r_c_lo   <= r_b_lo[15:0];
            r_c_qh   <= r_b_qr.q;
            r_c_n    <= n_c_n;
            r_c_est  <= f_est(n_c_n);
        end
        if (rdy_d && r_c_vld) begin
            r_d_torn <= r_c_torn;
            r_d_lo   <= r_c_lo;
            r_d_qh   <= r_c_qh;
            r_d_qr   <= fix_d;
        end
        if (rdy_e && r_d_vld) begin
            r_e_torn <= r_d_torn;
            r_e_qh   <= r_d_qh;
            r_e_qm   <= r_d_qr.q[15:0];
            r_e_n    <= n_e_n;
            r_e_est  <= f_est(n_e_n);
        end
        if (rdy_f && r_e_vld) begin
            r_f_torn <= r_e_torn;
            r_f_ms   <= {r_e_qh, r_e_qm, fix_f.q[15:0]};
        end
    end

    assign o_valid     = r_f_vld;
    assign o_item.torn = r_f_torn;
    assign o_item.ms   = r_f_ms;

endmodule

// ----- sv/t2ms_day_mod.sv -----
// ms mod 86400000: (ms >> 10) mod 84375 in 15-bit chunks, then low 10 bits appended.
module t2ms_day_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t2ms_pkg::t_ms_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output t2ms_pkg::t_day_item o_item
);

    localparam int MW = t2ms_pkg::MS_W;

    function automatic logic [15:0] f_est (input logic [31:0] n);
        logic [47:0] p;
        p = 48'(n) * 48'(t2ms_pkg::RECIP_DAY);
        return p[47:32];
    endfunction

    function automatic logic [16:0] f_rem (input logic [31:0] n, input logic [15:0] est);
        logic [31:0] back;
        logic [31:0] diff;
        back = 32'(est) * 32'(t2ms_pkg::DAY_DIV);
        diff = n - back;   // below twice the divisor
        if (diff[17:0] >= 18'(t2ms_pkg::DAY_DIV)) begin
            return 17'(diff[17:0] - 18'(t2ms_pkg::DAY_DIV));
        end
        return diff[16:0];
    endfunction

    logic          r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic          r_a_torn, r_b_torn, r_c_torn, r_d_torn;
    logic [MW-1:0] r_a_ms, r_b_ms, r_c_ms, r_d_ms;
    logic [31:0]   r_a_n, r_c_n;
    logic [15:0]   r_a_est, r_c_est;
    logic [16:0]   r_b_rem, r_d_rem;

    logic        rdy_a, rdy_b, rdy_c, rdy_d;
    logic [31:0] n_a_n, n_c_n;

    assign rdy_d = !r_d_vld || i_ready;
    assign rdy_c = !r_c_vld || rdy_d;
    assign rdy_b = !r_b_vld || rdy_c;
    assign rdy_a = !r_a_vld || rdy_b;
    assign o_ready = rdy_a;

    // top 15-bit chunk is already below the divisor
    assign n_a_n = {2'd0, i_item.ms[54:40], i_item.ms[39:25]};
    assign n_c_n = {r_b_rem, r_b_ms[24:10]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_valid;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_torn <= i_item.torn;
            r_a_ms   <= i_item.ms;
            r_a_n    <= n_a_n;
            r_a_est  <= f_est(n_a_n);
        end
        if (rdy_b && r_a_vld) begin
            r_b_torn <= r_a_torn;
            r_b_ms   <= r_a_ms;
            r_b_rem  <= f_rem(r_a_n, r_a_est);
        end
        if (rdy_c && r_b_vld) begin
            r_c_torn <= r_b_torn;
            r_c_ms   <= r_b_ms;
            r_c_n    <= n_c_n;
            r_c_est  <= f_est(n_c_n);
        end
        if (rdy_d && r_c_vld) begin
            r_d_torn <= r_c_torn;
            r_d_ms   <= r_c_ms;
            r_d_rem  <= f_rem(r_c_n, r_c_est);
        end
    end

    assign o_valid           = r_d_vld;
    assign o_item.torn       = r_d_torn;
    assign o_item.ms         = r_d_ms;
    assign o_item.ms_mod_day = {r_d_rem, r_d_ms[t2ms_pkg::DAY_SHIFT-1:0]};

endmodule

// ----- sv/t2ms_tod.sv -----
// Midnight tracking and result register.
module t2ms_tod (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t2ms_pkg::t_day_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t2ms_pkg::t_out_item  o_item
);

    localparam int MW = t2ms_pkg::MS_W;
    localparam int TW = t2ms_pkg::TOD_W;

    logic                 r_vld;
    logic [MW-1:0]        r_midnight;
    t2ms_pkg::t_out_item  r_out;

    logic          adv;
    logic [MW:0]   gap;
    logic          in_day;
    logic [TW-1:0] tod;

    assign adv     = !r_vld || i_ready;
    assign o_ready = adv;

    always_comb begin
        gap    = {1'b0, i_item.ms} - {1'b0, r_midnight};
        // midnight above current time wraps to a huge gap
        in_day = !gap[MW] && (gap[MW-1:0] < MW'(t2ms_pkg::MS_PER_DAY));
        tod    = in_day ? gap[TW-1:0] : i_item.ms_mod_day;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_midnight <= '0;
        end else begin
            if (adv) r_vld <= i_valid;
            if (adv && i_valid && !i_item.torn && !in_day) begin
                r_midnight <= i_item.ms - MW'(i_item.ms_mod_day);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_out.status            <= i_item.torn;
            r_out.ms_since_epoch    <= i_item.torn ? '0 : i_item.ms;
            r_out.ms_since_midnight <= i_item.torn ? '0 : tod;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_out;

endmodule

// ----- sv/t2ms_chk.sv -----
module t2ms_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t2ms_pkg::t_in_item   i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t2ms_pkg::t_out_item  o_out_item
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input item changed while waiting");

    // torn item carries zero time fields
    a_torn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |->
            o_out_item.ms_since_epoch == '0 && o_out_item.ms_since_midnight == '0)
        else $error("torn item with nonzero time");

    // time of day stays within one day and never exceeds epoch ms
    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.status |->
            o_out_item.ms_since_midnight < t2ms_pkg::MS_PER_DAY &&
            55'(o_out_item.ms_since_midnight) <= o_out_item.ms_since_epoch)
        else $error("time of day out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

endmodule

bind timestamp_to_ms_time_of_day_core t2ms_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for timestamp_to_ms_time_of_day_core.
module tb_top;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_TORN = 1'b1;

    localparam logic [63:0] DAY_US      = 64'd86_400_000_000;
    localparam int          RAND_READS  = 700;
    localparam int          HOLD_AT     = 300;     // items sent before the long output hold
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_AT    = 350;     // random item that waits for an empty pipe
    localparam int          TAIL_CYCLES = 30;
    localparam int          CYCLE_LIMIT = 500_000;

    // one pending counter read; drain_first holds it back until all results are in
    typedef struct {
        t2ms_pkg::t_in_item rd;
        bit                 drain_first;
    } t_read_slot;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid  = 1'b0;
    t2ms_pkg::t_in_item  in_item   = '0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t2ms_pkg::t_out_item out_item;

    t_read_slot          reads_q[$];     // counter reads not yet offered
    t2ms_pkg::t_out_item times_due[$];   // predicted results, oldest first
    logic [63:0] day_start_ms = '0;   // predictor's copy of the stored midnight
    bit          drain_next = 1'b0;

    int unsigned send_gap  = 0;
    int unsigned send_calm = 0;
    int unsigned recv_gap  = 0;
    int unsigned recv_calm = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned sent_cnt  = 0;
    int unsigned fail_cnt  = 0;
    int unsigned cycle_cnt = 0;

    timestamp_to_ms_time_of_day_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Expected result for one read; moves the midnight copy like the block does.
    function automatic t2ms_pkg::t_out_item predict_time(input t2ms_pkg::t_in_item rd);
        logic [63:0]         count;
        logic [63:0]         ms;
        logic [63:0]         since;
        t2ms_pkg::t_out_item res;
        res = '0;
        // torn read: upper word went backwards, nothing changes
        if (rd.upper_second < rd.upper_first) begin
            res.status = ST_TORN;
            return res;
        end
        // upper word rose between reads: the lower word is stale, count it as 0
        count = {rd.upper_second,
                 (rd.upper_second > rd.upper_first) ? 32'd0 : rd.lower_word};
        ms    = count / 64'(t2ms_pkg::US_PER_MS);
        // gap wraps mod 2^64, so a midnight above now also lands here
        since = ms - day_start_ms;
        if (since >= 64'(t2ms_pkg::MS_PER_DAY)) begin
            since        = ms % 64'(t2ms_pkg::MS_PER_DAY);
            day_start_ms = ms - since;
        end
        res.status            = ST_OK;
        res.ms_since_epoch    = ms[t2ms_pkg::MS_W-1:0];
        res.ms_since_midnight = since[t2ms_pkg::TOD_W-1:0];
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_read(input logic [31:0] hi_a, input logic [31:0] lo,
                             input logic [31:0] hi_b);
        t_read_slot slot;
        slot.rd.upper_first  = hi_a;
        slot.rd.lower_word   = lo;
        slot.rd.upper_second = hi_b;
        slot.drain_first     = drain_next;
        drain_next           = 1'b0;
        reads_q.push_back(slot);
    endtask

    // consistent read of a full count
    task automatic push_count(input logic [63:0] count);
        push_read(count[63:32], count[31:0], count[63:32]);
    endtask

    // Stimulus, reset, and end of run.
    initial begin
        logic [63:0] cur;
        logic [31:0] hi;
        int unsigned pick;

        // directed: extremes, rising upper, torn reads, day edges, midnight above now
        push_read(32'h0, 32'h0, 32'h0);
        push_read(32'h0, 32'd999, 32'h0);
        push_read(32'h0, 32'd1000, 32'h0);
        push_count(DAY_US - 1);                 // last ms of day zero
        push_count(DAY_US);                     // gap of exactly a day
        push_read(32'd5, 32'hffff_ffff, 32'd6); // rose, and midnight above now
        push_read(32'd7, 32'd123, 32'd6);       // torn
        push_read(32'hffff_ffff, 32'hffff_ffff, 32'h0);
        push_read(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_read(32'h0, 32'd12345678, 32'h0);  // back below midnight
        push_read(32'h0, 32'hffff_ffff, 32'hffff_ffff);
        push_read(32'h0, 32'hffff_ffff, 32'h1);
        push_count(3 * DAY_US + 5000);
        push_count(3 * DAY_US + 5999);
        push_read(32'h1, 32'h0, 32'h0);         // torn, midnight must stay put
        push_count(4 * DAY_US - 1);
        push_count(4 * DAY_US);
        push_count(5 * DAY_US - 1000);          // one ms short of a full day
        push_read(32'h1234_5678, 32'ha5a5_a5a5, 32'h1234_5678);
        push_read(32'h5a5a_5a5a, 32'h5a5a_5a5a, 32'h5a5a_5a5a);

        // random: mostly a running clock read cleanly, plus rose/torn/noise/jumps
        cur = {$urandom, $urandom};
        for (int n = 0; n < RAND_READS; n++) begin
            if (n == 0 || n == DRAIN_AT) drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            hi   = cur[63:32];
            if (pick < 50) begin
                cur = cur + 64'($urandom_range(0, 5_000_000));
                push_count(cur);
            end else if (pick < 58) begin
                cur = cur + {26'h0, 6'($urandom_range(0, 63)), 32'($urandom)};
                push_count(cur);
            end else if (pick < 64) begin
                // park just below a day edge so the next steps cross it
                cur = (cur / DAY_US + 1) * DAY_US - 64'($urandom_range(0, 3000));
                push_count(cur);
            end else if (pick < 75) begin
                push_read(hi, $urandom, hi + 32'($urandom_range(1, 3)));
                cur = {hi + 32'd1, 32'h0};
            end else if (pick < 85) begin
                push_read(hi, $urandom, hi - 32'($urandom_range(1, 4)));
            end else if (pick < 95) begin
                push_read($urandom, $urandom, $urandom);
            end else begin
                cur = {$urandom, $urandom};
                push_count(cur);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (reads_q.size() != 0 || in_valid || times_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && times_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Driver: predicts on accept, holds while stalled, then gap or next item.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                times_due.push_back(predict_time(in_item));
                sent_cnt <= sent_cnt + 1;
            end
            if (in_valid && !in_ready) begin
                // item still waiting, payload held
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (reads_q.size() != 0 &&
                         !(reads_q[0].drain_first && times_due.size() != 0)) begin
                in_item  <= reads_q[0].rd;
                in_valid <= 1'b1;
                reads_q.pop_front();
                if (send_calm != 0) begin
                    send_calm <= send_calm - 1;
                    send_gap  <= 0;
                end else begin
                    send_gap <= pick_gap();
                    if ($urandom_range(0, 19) == 0) send_calm <= $urandom_range(16, 64);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result, and drives ready with random stalls
    // plus one long hold that backs the pipe up into the input.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin : check_result
                t2ms_pkg::t_out_item want;
                if (times_due.size() == 0) begin
                    $error("unexpected result %p", out_item);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = times_due.pop_front();
                    if (out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (out_item.ms_since_epoch !== want.ms_since_epoch) begin
                        $error("ms_since_epoch: expected %0d, got %0d",
                               want.ms_since_epoch, out_item.ms_since_epoch);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (out_item.ms_since_midnight !== want.ms_since_midnight) begin
                        $error("ms_since_midnight: expected %0d, got %0d",
                               want.ms_since_midnight, out_item.ms_since_midnight);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (recv_calm != 0) begin
                    recv_calm <= recv_calm - 1;
                    recv_gap  <= 0;
                end else begin
                    recv_gap <= pick_gap();
                    if ($urandom_range(0, 19) == 0) recv_calm <= $urandom_range(16, 64);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
